// ===== hw/rtl/mcpt_pkg.sv =====
// mcpt_pkg: shared types and codes for the min cost path table
// holds request/response payload structs, operation and status codes
// no dependencies
package mcpt_pkg;

   localparam int SLOTS_DEFAULT      = 8;
   localparam int HOP_WEIGHT_DEFAULT = 16;

   localparam logic [1:0] FUNC_INSERT   = 2'd0;
   localparam logic [1:0] FUNC_DELETE   = 2'd1;
   localparam logic [1:0] FUNC_PENALIZE = 2'd2;
   localparam logic [1:0] FUNC_BEST     = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_VALID = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   localparam logic [7:0] PENALTY_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] slot;
      logic [4:0] path_length;
      logic [7:0] start_penalty;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] result_slot;
      logic [4:0] result_length;
      logic [7:0] result_penalty;
      logic [3:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [4:0] length;
      logic [7:0] penalty;
   } path_type;

   // operation driven to every cell while a transfer is in flight
   typedef struct packed {
      logic [1:0] func;
      logic [2:0] slot;
   } cmd_type;

   // table update broadcast at the end of an operation
   typedef struct packed {
      logic     en;
      path_type path;
   } commit_type;

endpackage

// ===== hw/rtl/mcpt_cell.sv =====
// mcpt_cell: one table entry plus one stage of the scan chain
// holds valid, age rank, path and cost; passes the running candidate on
// depends on mcpt_pkg
module mcpt_cell #(
   parameter int IDX_W      = 3,
   parameter int COST_W     = 17,
   parameter int INDEX      = 0,
   parameter int HOP_WEIGHT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mcpt_pkg::cmd_type    cmd,
   input  mcpt_pkg::commit_type commit,
   input  logic [IDX_W-1:0]     commit_slot,
   input  logic [IDX_W-1:0]     commit_age,
   input  logic [COST_W-1:0]    commit_cost,
   input  logic                 in_found,
   input  logic [IDX_W-1:0]     in_slot,
   input  logic [IDX_W-1:0]     in_age,
   input  logic [COST_W-1:0]    in_cost,
   input  mcpt_pkg::path_type   in_path,
   output logic                 out_found,
   output logic [IDX_W-1:0]     out_slot,
   output logic [IDX_W-1:0]     out_age,
   output logic [COST_W-1:0]    out_cost,
   output mcpt_pkg::path_type   out_path
);
   import mcpt_pkg::*;

   localparam logic [IDX_W-1:0]  MY_IDX = IDX_W'(INDEX);
   localparam logic [COST_W-1:0] WEIGHT = COST_W'(HOP_WEIGHT);

   logic              valid_ff, valid_in;
   logic [IDX_W-1:0]  age_ff, age_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   path_type          path_ff, path_in;

   logic              found_ff;
   logic [IDX_W-1:0]  slot_ff, tok_age_ff;
   logic [COST_W-1:0] tok_cost_ff;
   path_type          tok_path_ff;

   logic take;
   logic is_tgt;

   // candidate selection
   always_comb begin
      take = 1'b0;
      case (cmd.func)
         FUNC_INSERT: begin
            take = !in_found && !valid_ff;
         end
         FUNC_DELETE, FUNC_PENALIZE: begin
            take = valid_ff && (32'(cmd.slot) == INDEX);
         end
         FUNC_BEST: begin
            take = valid_ff && (!in_found || (cost_ff < in_cost) ||
                   ((cost_ff == in_cost) && (age_ff < in_age)));
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= in_found || take;
      end
      if (take) begin
         slot_ff     <= MY_IDX;
         tok_age_ff  <= age_ff;
         tok_cost_ff <= cost_ff;
         tok_path_ff <= path_ff;
      end else begin
         slot_ff     <= in_slot;
         tok_age_ff  <= in_age;
         tok_cost_ff <= in_cost;
         tok_path_ff <= in_path;
      end
   end

   assign out_found = found_ff;
   assign out_slot  = slot_ff;
   assign out_age   = tok_age_ff;
   assign out_cost  = tok_cost_ff;
   assign out_path  = tok_path_ff;

   // entry update
   assign is_tgt = (commit_slot == MY_IDX);

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      cost_in  = cost_ff;
      path_in  = path_ff;
      if (commit.en) begin
         case (cmd.func)
            FUNC_INSERT: begin
               if (is_tgt) begin
                  valid_in = 1'b1;
                  age_in   = '0;
                  cost_in  = commit_cost;
                  path_in  = commit.path;
               end else if (valid_ff) begin
                  age_in = age_ff + 1'b1;
               end
            end
            FUNC_DELETE: begin
               if (is_tgt) begin
                  valid_in = 1'b0;
               end else if (valid_ff && (age_ff > commit_age)) begin
                  age_in = age_ff - 1'b1;
               end
            end
            FUNC_PENALIZE: begin
               if (is_tgt && (path_ff.penalty != PENALTY_MAX)) begin
                  path_in.penalty = path_ff.penalty + 8'd1;
                  cost_in         = cost_ff + WEIGHT;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      age_ff  <= age_in;
      cost_ff <= cost_in;
      path_ff <= path_in;
   end

endmodule

// ===== hw/rtl/mcpt_seq.sv =====
// mcpt_seq: operation sequencer and response register
// runs the scan down the cell chain, then commits and builds the response
// depends on mcpt_pkg
module mcpt_seq #(
   parameter int SLOTS      = 8,
   parameter int IDX_W      = 3,
   parameter int COST_W     = 17,
   parameter int HOP_WEIGHT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mcpt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mcpt_pkg::rsp_type    rsp_data,
   output mcpt_pkg::cmd_type    cmd,
   output mcpt_pkg::commit_type commit,
   output logic [IDX_W-1:0]     commit_slot,
   output logic [IDX_W-1:0]     commit_age,
   output logic [COST_W-1:0]    commit_cost,
   input  logic                 tail_found,
   input  logic [IDX_W-1:0]     tail_slot,
   input  logic [IDX_W-1:0]     tail_age,
   input  mcpt_pkg::path_type   tail_path
);
   import mcpt_pkg::*;

   localparam int               CNT_W    = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [1:0]       ST_IDLE  = 2'd0;
   localparam logic [1:0]       ST_SCAN  = 2'd1;
   localparam logic [1:0]       ST_DONE  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type          req_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             load;

   assign req_ready = (state_ff == ST_IDLE);
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
               step_in  = '0;
            end
         end
         ST_SCAN: begin
            if (step_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response and entry count
   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      case (req_ff.func)
         FUNC_INSERT: begin
            if (tail_found) begin
               count_in           = count_ff + 1'b1;
               rsp_in.status      = STATUS_OK;
               rsp_in.result_slot = 3'(tail_slot);
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end
         FUNC_DELETE: begin
            if (tail_found) begin
               count_in      = count_ff - 1'b1;
               rsp_in.status = STATUS_OK;
            end else begin
               rsp_in.status = STATUS_NOT_VALID;
            end
         end
         FUNC_PENALIZE: begin
            rsp_in.status = tail_found ? STATUS_OK : STATUS_NOT_VALID;
         end
         FUNC_BEST: begin
            if (tail_found) begin
               rsp_in.status         = STATUS_OK;
               rsp_in.result_slot    = 3'(tail_slot);
               rsp_in.result_length  = tail_path.length;
               rsp_in.result_penalty = tail_path.penalty;
            end else begin
               rsp_in.status = STATUS_EMPTY;
            end
         end
         default: begin
            rsp_in.status = STATUS_OK;
         end
      endcase
      rsp_in.entry_count = 4'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            count_ff <= count_in;
         end
      end
      step_ff <= step_in;
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cmd.func          = req_ff.func;
   assign cmd.slot          = req_ff.slot;
   assign commit.en         = load && tail_found && (req_ff.func != FUNC_BEST);
   assign commit.path       = '{length: req_ff.path_length, penalty: req_ff.start_penalty};
   assign commit_slot       = tail_slot;
   assign commit_age        = tail_age;
   assign commit_cost       = COST_W'(req_ff.path_length) +
                              COST_W'(req_ff.start_penalty) * COST_W'(HOP_WEIGHT);

endmodule

// ===== hw/rtl/min_cost_path_table.sv =====
// Min cost path table: SLOTS candidate routes, each with hop length and penalty.
// Request channel (req_valid/req_ready/req_data) carries one operation:
// insert, delete, penalize or find best path. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns one result per request with status,
// slot, best path fields and the entry count after the operation.
// Each request runs a candidate down a chain of SLOTS cells, one cell per
// cycle; the done state then commits the update and loads the response
// register. A new request is taken only after the previous one has loaded
// its response.
// Best path cost is length + penalty * HOP_WEIGHT, ties go to the newest entry.
// Reset empties the table; entry contents need no clearing.
// A stalled response holds in its register; the block scans the next request
// meanwhile and waits to commit it until the response register is free.
// depends on mcpt_pkg, mcpt_cell, mcpt_seq
module min_cost_path_table #(
   parameter int SLOTS      = mcpt_pkg::SLOTS_DEFAULT,
   parameter int HOP_WEIGHT = mcpt_pkg::HOP_WEIGHT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcpt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcpt_pkg::rsp_type rsp_data
);
   import mcpt_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int COST_W = $clog2(31 + 255 * HOP_WEIGHT + 1);

   cmd_type           cmd;
   commit_type        commit;
   logic [IDX_W-1:0]  commit_slot;
   logic [IDX_W-1:0]  commit_age;
   logic [COST_W-1:0] commit_cost;

   logic              tok_found [0:SLOTS];
   logic [IDX_W-1:0]  tok_slot  [0:SLOTS];
   logic [IDX_W-1:0]  tok_age   [0:SLOTS];
   logic [COST_W-1:0] tok_cost  [0:SLOTS];
   path_type          tok_path  [0:SLOTS];

   assign tok_found[0] = 1'b0;
   assign tok_slot[0]  = '0;
   assign tok_age[0]   = '0;
   assign tok_cost[0]  = '0;
   assign tok_path[0]  = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      mcpt_cell #(
         .IDX_W      (IDX_W),
         .COST_W     (COST_W),
         .INDEX      (g),
         .HOP_WEIGHT (HOP_WEIGHT)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .commit      (commit),
         .commit_slot (commit_slot),
         .commit_age  (commit_age),
         .commit_cost (commit_cost),
         .in_found    (tok_found[g]),
         .in_slot     (tok_slot[g]),
         .in_age      (tok_age[g]),
         .in_cost     (tok_cost[g]),
         .in_path     (tok_path[g]),
         .out_found   (tok_found[g+1]),
         .out_slot    (tok_slot[g+1]),
         .out_age     (tok_age[g+1]),
         .out_cost    (tok_cost[g+1]),
         .out_path    (tok_path[g+1])
      );
   end

   mcpt_seq #(
      .SLOTS      (SLOTS),
      .IDX_W      (IDX_W),
      .COST_W     (COST_W),
      .HOP_WEIGHT (HOP_WEIGHT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .commit      (commit),
      .commit_slot (commit_slot),
      .commit_age  (commit_age),
      .commit_cost (commit_cost),
      .tail_found  (tok_found[SLOTS]),
      .tail_slot   (tok_slot[SLOTS]),
      .tail_age    (tok_age[SLOTS]),
      .tail_path   (tok_path[SLOTS])
   );

endmodule

// ===== hw/rtl/mcpt_checker.sv =====
// mcpt_checker: port level assertions for the min cost path table
// bound to min_cost_path_table; depends on mcpt_pkg
module mcpt_checker #(
   parameter int SLOTS = mcpt_pkg::SLOTS_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mcpt_pkg::rsp_type rsp_data
);
   import mcpt_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one operation in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during an operation");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |->
      rsp_data.entry_count == 4'(SLOTS))
      else $error("table full reported below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_EMPTY) |-> rsp_data.entry_count == 4'd0)
      else $error("table empty reported with entries");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |->
      (rsp_data.result_slot == 3'd0) && (rsp_data.result_length == 5'd0) &&
      (rsp_data.result_penalty == 8'd0))
      else $error("error response carries data");

endmodule

bind min_cost_path_table mcpt_checker #(.SLOTS(SLOTS)) u_mcpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
